### hdl/rdab_pkg.sv
// Shared types, widths and codes for the receive dedupe and ack bitmap block.
package rdab_pkg;

  localparam int SEQ_W          = 16;
  localparam int STATUS_W       = 2;
  localparam int SEEN_MASK_W    = 32;
  localparam int ENTRY_W        = SEQ_W + 1;
  localparam int SLOT_COUNT_DEF = 256;
  localparam int ACK_WINDOW_DEF = 32;

  localparam logic [STATUS_W-1:0] STATUS_NEW = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DUP = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OLD = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECIDE,
    ST_SWEEP,
    ST_LOOKUP,
    ST_CHECK,
    ST_ACK,
    ST_DONE
  } state_t;

  // Result of one slot probe, available in the cycle after the read was issued.
  typedef struct packed {
    logic pend;
    logic hit;
    logic differs;
  } probe_res_t;

endpackage

### hdl/receive_dedupe_ack_bitmap_core.sv
// Top level of the receive dedupe filter with acknowledgement bitmap.
//
// Each item is a 16-bit received sequence number; each yields one result with the
// status (new, duplicate, too old), the newest sequence and the ack bitmap. All slot
// state sits in one RAM of SLOT_COUNT entries ({valid, tag}) with a single read and
// a single write port, probed one slot per cycle by a shared add/compare unit. An
// item inside the window gets a slot lookup and then one probe per bitmap bit before
// the input opens again; a too-old item skips the lookup. An item that advances the
// window first sweeps the skipped slots and invalidates those that do not hold the
// skipped sequence. A new result waits while an older, stalled result still sits in
// the output register. The block takes one item at a time; a finished result waits
// in the output register while the next item is accepted. After reset a clearing
// pass writes every RAM entry, and in_stall stays high until it ends.
module receive_dedupe_ack_bitmap_core #(
  parameter int SLOT_COUNT = rdab_pkg::SLOT_COUNT_DEF,
  parameter int ACK_WINDOW = rdab_pkg::ACK_WINDOW_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [rdab_pkg::SEQ_W-1:0]       in_rx_sequence,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [rdab_pkg::STATUS_W-1:0]    out_status,
  output logic [rdab_pkg::SEQ_W-1:0]       out_ack_sequence,
  output logic [rdab_pkg::SEEN_MASK_W-1:0] out_seen_mask
);

  localparam int IDX_W     = $clog2(SLOT_COUNT);
  localparam int WIN_CNT_W = $clog2(ACK_WINDOW + 1);
  localparam int CNT_W     = (IDX_W + 1 > WIN_CNT_W) ? IDX_W + 1 : WIN_CNT_W;
  localparam logic [rdab_pkg::SEQ_W:0] SLOT_COUNT_L = (rdab_pkg::SEQ_W + 1)'(SLOT_COUNT);

  rdab_pkg::state_t state_r, state_nxt;

  logic [rdab_pkg::SEQ_W-1:0]    seq_r, seq_nxt;
  logic [rdab_pkg::SEQ_W-1:0]    gap_r, gap_nxt;
  logic [rdab_pkg::SEQ_W-1:0]    newest_r, newest_nxt;
  logic                          seen_any_r, seen_any_nxt;
  logic [rdab_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [IDX_W-1:0]              last_r, last_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [ACK_WINDOW-1:0]         bits_r, bits_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [rdab_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [rdab_pkg::SEQ_W-1:0]    out_ack_sequence_r, out_ack_sequence_nxt;
  logic [rdab_pkg::SEEN_MASK_W-1:0] out_seen_mask_r, out_seen_mask_nxt;

  // Probe unit and RAM hookup
  logic                          probe_issue;
  logic [rdab_pkg::SEQ_W-1:0]    probe_base;
  logic [rdab_pkg::SEQ_W-1:0]    probe_off;
  logic                          probe_sub;
  logic                          ram_re;
  logic [IDX_W-1:0]              ram_raddr;
  logic [rdab_pkg::ENTRY_W-1:0]  ram_rdata;
  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr;
  logic [rdab_pkg::ENTRY_W-1:0]  ram_wdata;
  rdab_pkg::probe_res_t          res;
  logic [IDX_W-1:0]              res_addr;
  logic [rdab_pkg::SEQ_W-1:0]    res_tag;

  // Decision terms
  logic                          is_newer;
  logic [rdab_pkg::SEQ_W-1:0]    age;
  logic                          too_old;
  logic                          gap_full;
  logic                          sweep_issue;
  logic                          ack_issue;
  logic                          out_load;
  logic [ACK_WINDOW:0]           shift_w;

  assign is_newer    = (gap_r != '0) && !gap_r[rdab_pkg::SEQ_W-1];
  assign age         = ~gap_r + 16'd1;
  assign too_old     = {1'b0, age} >= SLOT_COUNT_L;
  assign gap_full    = {1'b0, gap_r} >= SLOT_COUNT_L;
  assign sweep_issue = cnt_r <= CNT_W'(last_r);
  assign ack_issue   = cnt_r < CNT_W'(ACK_WINDOW);
  assign out_load    = (state_r == rdab_pkg::ST_DONE) && (!out_valid_r || !out_stall);
  assign shift_w     = {res.hit, bits_r};

  rdab_probe #(
    .IDX_W(IDX_W)
  ) u_probe (
    .clk      (clk),
    .rst_n    (rst_n),
    .issue    (probe_issue),
    .base     (probe_base),
    .offset   (probe_off),
    .subtract (probe_sub),
    .rd_en    (ram_re),
    .rd_addr  (ram_raddr),
    .rd_data  (ram_rdata),
    .res      (res),
    .res_addr (res_addr),
    .res_tag  (res_tag)
  );

  rdab_ram #(
    .WIDTH(rdab_pkg::ENTRY_W),
    .DEPTH(SLOT_COUNT)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rdab_pkg::ST_CLEAR: begin
        if (cnt_r == CNT_W'(SLOT_COUNT - 1)) state_nxt = rdab_pkg::ST_IDLE;
      end
      rdab_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = rdab_pkg::ST_DECIDE;
      end
      rdab_pkg::ST_DECIDE: begin
        priority if (!seen_any_r) state_nxt = rdab_pkg::ST_LOOKUP;
        else if (is_newer)        state_nxt = rdab_pkg::ST_SWEEP;
        else if (too_old)         state_nxt = rdab_pkg::ST_ACK;
        else                      state_nxt = rdab_pkg::ST_LOOKUP;
      end
      rdab_pkg::ST_SWEEP: begin
        if (!sweep_issue && !res.pend) state_nxt = rdab_pkg::ST_LOOKUP;
      end
      rdab_pkg::ST_LOOKUP: state_nxt = rdab_pkg::ST_CHECK;
      rdab_pkg::ST_CHECK:  state_nxt = rdab_pkg::ST_ACK;
      rdab_pkg::ST_ACK: begin
        if (!ack_issue && !res.pend) state_nxt = rdab_pkg::ST_DONE;
      end
      rdab_pkg::ST_DONE: begin
        if (out_load) state_nxt = rdab_pkg::ST_IDLE;
      end
      default: state_nxt = rdab_pkg::ST_CLEAR;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    seq_nxt              = seq_r;
    gap_nxt              = gap_r;
    newest_nxt           = newest_r;
    seen_any_nxt         = seen_any_r;
    status_nxt           = status_r;
    last_nxt             = last_r;
    cnt_nxt              = cnt_r;
    bits_nxt             = bits_r;
    out_status_nxt       = out_status_r;
    out_ack_sequence_nxt = out_ack_sequence_r;
    out_seen_mask_nxt    = out_seen_mask_r;
    out_valid_nxt        = out_valid_r && out_stall;
    probe_issue          = 1'b0;
    probe_base           = newest_r;
    probe_off            = '0;
    probe_sub            = 1'b0;
    ram_we               = 1'b0;
    ram_waddr            = res_addr;
    ram_wdata            = '0;

    unique case (state_r)
      rdab_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r[IDX_W-1:0];
        cnt_nxt   = cnt_r + CNT_W'(1);
      end
      rdab_pkg::ST_IDLE: begin
        if (in_valid) begin
          seq_nxt = in_rx_sequence;
          gap_nxt = in_rx_sequence - newest_r;
        end
      end
      rdab_pkg::ST_DECIDE: begin
        cnt_nxt = '0;
        priority if (!seen_any_r) begin
          seen_any_nxt = 1'b1;
          newest_nxt   = seq_r;
        end else if (is_newer) begin
          // sweep the skipped sequences, at most one ring's worth
          last_nxt = gap_full ? IDX_W'(SLOT_COUNT - 1) : (gap_r[IDX_W-1:0] - IDX_W'(1));
          cnt_nxt  = CNT_W'(1);
        end else if (too_old) begin
          status_nxt = rdab_pkg::STATUS_OLD;
        end else begin
          status_nxt = status_r;
        end
      end
      rdab_pkg::ST_SWEEP: begin
        if (sweep_issue) begin
          probe_issue = 1'b1;
          probe_off   = rdab_pkg::SEQ_W'(cnt_r);
          cnt_nxt     = cnt_r + CNT_W'(1);
        end
        // drop slots whose tag is not the skipped sequence
        if (res.pend && res.differs) begin
          ram_we    = 1'b1;
          ram_wdata = {1'b0, res_tag};
        end
        if (!sweep_issue && !res.pend) newest_nxt = seq_r;
      end
      rdab_pkg::ST_LOOKUP: begin
        probe_issue = 1'b1;
        probe_base  = seq_r;
      end
      rdab_pkg::ST_CHECK: begin
        cnt_nxt = '0;
        if (res.hit) begin
          status_nxt = rdab_pkg::STATUS_DUP;
        end else begin
          status_nxt = rdab_pkg::STATUS_NEW;
          ram_we     = 1'b1;
          ram_wdata  = {1'b1, seq_r};
        end
      end
      rdab_pkg::ST_ACK: begin
        if (ack_issue) begin
          probe_issue = 1'b1;
          probe_sub   = 1'b1;
          probe_off   = rdab_pkg::SEQ_W'(cnt_r) + 16'd1;
          cnt_nxt     = cnt_r + CNT_W'(1);
        end
        // shift in from the top so the first probe ends at bit 0
        if (res.pend) bits_nxt = shift_w[ACK_WINDOW:1];
      end
      rdab_pkg::ST_DONE: begin
        if (out_load) begin
          out_valid_nxt        = 1'b1;
          out_status_nxt       = status_r;
          out_ack_sequence_nxt = newest_r;
          out_seen_mask_nxt    = rdab_pkg::SEEN_MASK_W'(bits_r);
        end
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rdab_pkg::ST_CLEAR;
      cnt_r       <= '0;
      newest_r    <= '0;
      seen_any_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      newest_r    <= newest_nxt;
      seen_any_r  <= seen_any_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r              <= seq_nxt;
    gap_r              <= gap_nxt;
    status_r           <= status_nxt;
    last_r             <= last_nxt;
    bits_r             <= bits_nxt;
    out_status_r       <= out_status_nxt;
    out_ack_sequence_r <= out_ack_sequence_nxt;
    out_seen_mask_r    <= out_seen_mask_nxt;
  end

  assign in_stall         = (state_r != rdab_pkg::ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_ack_sequence = out_ack_sequence_r;
  assign out_seen_mask    = out_seen_mask_r;

endmodule

### hdl/rdab_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rdab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/rdab_probe.sv
// Shared slot probe: sequence add/subtract, slot address and tag compare.
module rdab_probe #(
  parameter int IDX_W = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        issue,
  input  logic [rdab_pkg::SEQ_W-1:0]  base,
  input  logic [rdab_pkg::SEQ_W-1:0]  offset,
  input  logic                        subtract,
  output logic                        rd_en,
  output logic [IDX_W-1:0]            rd_addr,
  input  logic [rdab_pkg::ENTRY_W-1:0] rd_data,
  output rdab_pkg::probe_res_t        res,
  output logic [IDX_W-1:0]            res_addr,
  output logic [rdab_pkg::SEQ_W-1:0]  res_tag
);

  logic [rdab_pkg::SEQ_W-1:0] probe_seq;
  logic [rdab_pkg::SEQ_W-1:0] seq_q_r;
  logic [IDX_W-1:0]           addr_q_r;
  logic                       pend_r;

  assign probe_seq = subtract ? (base - offset) : (base + offset);
  assign rd_en     = issue;
  assign rd_addr   = probe_seq[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= issue;
    end
  end

  // Hold the probed sequence to line up with the registered read.
  always_ff @(posedge clk) begin
    if (issue) begin
      seq_q_r  <= probe_seq;
      addr_q_r <= rd_addr;
    end
  end

  assign res_tag     = rd_data[rdab_pkg::SEQ_W-1:0];
  assign res_addr    = addr_q_r;
  assign res.pend    = pend_r;
  assign res.differs = (res_tag != seq_q_r);
  assign res.hit     = pend_r && rd_data[rdab_pkg::SEQ_W] && (res_tag == seq_q_r);

endmodule

### hdl/rdab_checker.sv
// Port-level checks for the receive dedupe core, bound to the top level.
module rdab_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic [rdab_pkg::SEQ_W-1:0]       in_rx_sequence,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [rdab_pkg::STATUS_W-1:0]    out_status,
  input logic [rdab_pkg::SEQ_W-1:0]       out_ack_sequence,
  input logic [rdab_pkg::SEEN_MASK_W-1:0] out_seen_mask
);

  // After reset the clearing pass holds off input and no result is shown.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("input open or result shown right after reset");

  // One item at a time: an accepted item makes the block busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input still open the cycle after an item was accepted");

  // A stalled input item stays put until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_rx_sequence))
    else $error("stalled input item withdrawn or changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result withdrawn");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_status) && $stable(out_ack_sequence)
                               && $stable(out_seen_mask))
    else $error("stalled result changed");

endmodule

bind receive_dedupe_ack_bitmap_core rdab_checker u_rdab_checker (.*);

### test/tb.sv
// Self-checking testbench for the receive dedupe filter with ack bitmap.
typedef struct {
  logic [rdab_pkg::STATUS_W-1:0]    status;
  logic [rdab_pkg::SEQ_W-1:0]       ack_seq;
  logic [rdab_pkg::SEEN_MASK_W-1:0] seen_mask;
} ack_report_t;

class ack_window_tracker;
  bit                         slot_ok [rdab_pkg::SLOT_COUNT_DEF];
  bit [rdab_pkg::SEQ_W-1:0]   slot_seq[rdab_pkg::SLOT_COUNT_DEF];
  bit [rdab_pkg::SEQ_W-1:0]   newest;
  bit                         seen_any;
  ack_report_t                ack_pending_q[$];
  int                         errors;

  function int slot_idx(bit [rdab_pkg::SEQ_W-1:0] s);
    return int'(s) % rdab_pkg::SLOT_COUNT_DEF;
  endfunction

  function bit holds(bit [rdab_pkg::SEQ_W-1:0] s);
    return slot_ok[slot_idx(s)] && slot_seq[slot_idx(s)] == s;
  endfunction

  // Predict the report for one accepted sequence number.
  function void note_rx(bit [rdab_pkg::SEQ_W-1:0] s);
    ack_report_t               r;
    bit [rdab_pkg::SEQ_W-1:0]  gap;
    bit [rdab_pkg::SEQ_W-1:0]  age;
    bit [rdab_pkg::SEQ_W-1:0]  p;
    int                        lim;
    int                        i;
    bit                        too_old;
    too_old = 1'b0;
    if (!seen_any) begin
      seen_any = 1'b1;
      newest   = s;
    end else begin
      gap = s - newest;
      if (gap >= 1 && gap <= 16'h7FFF) begin
        lim = (int'(gap) > rdab_pkg::SLOT_COUNT_DEF) ? rdab_pkg::SLOT_COUNT_DEF : int'(gap);
        // Drop skipped slots unless they already hold the skipped sequence.
        for (i = 1; i < lim; i++) begin
          p = newest + rdab_pkg::SEQ_W'(i);
          if (slot_seq[slot_idx(p)] != p) slot_ok[slot_idx(p)] = 1'b0;
        end
        newest = s;
      end else begin
        age = newest - s;
        if (int'(age) >= rdab_pkg::SLOT_COUNT_DEF) too_old = 1'b1;
      end
    end
    if (too_old) begin
      r.status = rdab_pkg::STATUS_OLD;
    end else if (holds(s)) begin
      r.status = rdab_pkg::STATUS_DUP;
    end else begin
      slot_ok[slot_idx(s)]  = 1'b1;
      slot_seq[slot_idx(s)] = s;
      r.status = rdab_pkg::STATUS_NEW;
    end
    r.ack_seq   = newest;
    r.seen_mask = '0;
    for (i = 0; i < rdab_pkg::ACK_WINDOW_DEF && i < rdab_pkg::SEEN_MASK_W; i++) begin
      if (holds(newest - rdab_pkg::SEQ_W'(i + 1))) r.seen_mask[i] = 1'b1;
    end
    ack_pending_q.push_back(r);
  endfunction

  function void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endfunction

  function void check_ack(logic [rdab_pkg::STATUS_W-1:0] status,
                          logic [rdab_pkg::SEQ_W-1:0] ack_seq,
                          logic [rdab_pkg::SEEN_MASK_W-1:0] seen_mask);
    ack_report_t r;
    if (ack_pending_q.size() == 0) begin
      $error("result with no item outstanding: status %0h ack_sequence %0h", status, ack_seq);
      errors++;
      return;
    end
    r = ack_pending_q.pop_front();
    compare_field("status", r.status, status);
    compare_field("ack_sequence", r.ack_seq, ack_seq);
    compare_field("seen_mask", r.seen_mask, seen_mask);
  endfunction

  function int pending();
    return ack_pending_q.size();
  endfunction
endclass

module tb;
  logic                             clk;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_stall;
  logic [rdab_pkg::SEQ_W-1:0]       in_rx_sequence;
  logic                             out_valid;
  logic                             out_stall;
  logic [rdab_pkg::STATUS_W-1:0]    out_status;
  logic [rdab_pkg::SEQ_W-1:0]       out_ack_sequence;
  logic [rdab_pkg::SEEN_MASK_W-1:0] out_seen_mask;

  ack_window_tracker sb = new();
  bit                no_idle;
  int                rx_hold;

  receive_dedupe_ack_bitmap_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_sequence  (in_rx_sequence),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_ack_sequence(out_ack_sequence),
    .out_seen_mask   (out_seen_mask)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Mostly short gaps, now and then a long one.
  function int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(15, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic send_seq(input logic [rdab_pkg::SEQ_W-1:0] s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_rx_sequence <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_rx(s);
  endtask

  // Pick the next sequence relative to the current newest.
  function logic [rdab_pkg::SEQ_W-1:0] pick_seq();
    int r;
    r = $urandom_range(99);
    if (r < 55) return sb.newest + rdab_pkg::SEQ_W'(int'($urandom_range(43)) - 40);
    if (r < 70) return sb.newest + rdab_pkg::SEQ_W'($urandom_range(300, 1));
    if (r < 80) return sb.newest - rdab_pkg::SEQ_W'($urandom_range(300, 200));
    if (r < 85) return sb.newest + rdab_pkg::SEQ_W'($urandom_range(32767, 257));
    if (r < 90) return sb.newest + rdab_pkg::SEQ_W'($urandom_range(32769, 32768));
    return rdab_pkg::SEQ_W'($urandom);
  endfunction

  // Withdraw the input, then wait until every report is back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Receiver: hold stall for a random number of cycles, then release.
  initial begin
    out_stall = 1'b0;
    rx_hold   = 0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_stall <= 1'b1;
        rx_hold--;
      end else begin
        out_stall <= 1'b0;
        rx_hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_ack(out_status, out_ack_sequence, out_seen_mask);
  end

  initial begin
    logic [rdab_pkg::SEQ_W-1:0] directed_q[$];
    int n;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_rx_sequence = '0;
    no_idle        = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // First item, duplicates, window edges, gaps past the ring size, wrap-around.
    directed_q = '{16'h0000, 16'h0000, 16'hFFFF, 16'h0001, 16'h0005, 16'h0003,
                   16'h0003, 16'h0005, 16'hFF06, 16'hFF05, 16'h8005, 16'h0105,
                   16'h0405, 16'h0406, 16'h8405, 16'h8404, 16'hFFF0, 16'hFFEF,
                   16'h0008, 16'hFFF1, 16'h5555, 16'hAAAA, 16'hAA8A, 16'hAAAA};
    foreach (directed_q[i]) send_seq(directed_q[i]);

    for (n = 0; n < 400; n++) begin
      no_idle = (n >= 150 && n < 230);
      if (n == 100 || n == 300) begin
        // Hold off until every report is back.
        drain();
      end
      send_seq(pick_seq());
    end

    drain();
    repeat (64) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(12 * 1000000);
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
